[sv/rdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types, constants and the digit-to-ASCII mapping of the radix digit
// formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

  localparam int VALUE_BITS = 31;   // magnitude bits of a positive value
  localparam int STEP_W     = 5;    // counts the divide steps of one digit
  localparam int DIGIT_W    = 6;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A      = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_QMARK  = 7'h3F;
  localparam logic [CHAR_W-1:0]  ASCII_NL     = 7'h0A;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS   = 6'd10;
  localparam logic [DIGIT_W-1:0] ALNUM_DIGITS = 6'd36;
  localparam logic [RADIX_W-1:0] MIN_RADIX    = 6'd2;

  typedef struct packed {
    logic signed [31:0]   value;
    logic [RADIX_W-1:0]   radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_radix;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // take a new transaction
    logic div_step;   // one restoring divide step
    logic emit;       // show the digit read from the store
    logic newline;    // show the closing newline
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_zero;
    logic cnt_full;
    logic cnt_zero;
    logic cnt_one;
    logic div_last;
  } dp_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DEC_DIGITS) begin
      ch = ASCII_ZERO + {1'b0, d};
    end else if (d < ALNUM_DIGITS) begin
      ch = ASCII_A + {1'b0, d} - {1'b0, DEC_DIGITS};
    end else begin
      ch = ASCII_QMARK;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

[sv/rdf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdf_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/rdf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_datapath
// Bit-serial restoring divider, digit store and result register.
// ----------------------------------------------------------------------------
module rdf_datapath #(
  parameter int DIGIT_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rdf_pkg::in_t      in_data,
  input  wire rdf_pkg::dp_cmd_t  cmd,
  output rdf_pkg::dp_stat_t      stat,
  output logic                   out_valid,
  output rdf_pkg::out_t          out_data
);

  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  logic [rdf_pkg::VALUE_BITS-1:0] rem_r,    rem_nxt;
  logic [rdf_pkg::DIGIT_W-1:0]    part_r,   part_nxt;
  logic [rdf_pkg::RADIX_W-1:0]    radix_r,  radix_nxt;
  logic                           bad_r,    bad_nxt;
  logic [rdf_pkg::STEP_W-1:0]     step_r,   step_nxt;
  logic [CW-1:0]                  cnt_r,    cnt_nxt;
  logic                           valid_r,  valid_nxt;
  rdf_pkg::out_t                  out_r,    out_nxt;

  logic [rdf_pkg::DIGIT_W:0]   trial;
  logic                        fits;
  logic [rdf_pkg::DIGIT_W-1:0] part_step;
  logic                        div_last;
  logic                        store_we;
  logic [CW-1:0]               cnt_dec;
  logic [rdf_pkg::DIGIT_W-1:0] rd_digit;
  logic                        bad_in;

  assign bad_in    = in_data.radix < rdf_pkg::MIN_RADIX;
  assign trial     = {part_r, rem_r[rdf_pkg::VALUE_BITS-1]};
  assign fits      = trial >= {1'b0, radix_r};
  assign part_step = fits ? rdf_pkg::DIGIT_W'(trial - {1'b0, radix_r})
                          : trial[rdf_pkg::DIGIT_W-1:0];
  assign div_last  = step_r == rdf_pkg::STEP_W'(rdf_pkg::VALUE_BITS - 1);
  assign store_we  = cmd.div_step && div_last;
  assign cnt_dec   = cnt_r - CW'(1);

  rdf_ram #(
    .WIDTH (rdf_pkg::DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (part_step),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (rd_digit)
  );

  always_comb begin
    rem_nxt   = rem_r;
    part_nxt  = part_r;
    radix_nxt = radix_r;
    bad_nxt   = bad_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    valid_nxt = 1'b0;
    out_nxt   = out_r;
    if (cmd.load) begin
      rem_nxt   = (bad_in || in_data.value[31]) ? '0 : in_data.value[rdf_pkg::VALUE_BITS-1:0];
      part_nxt  = '0;
      radix_nxt = in_data.radix;
      bad_nxt   = bad_in;
      step_nxt  = '0;
      cnt_nxt   = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = {rem_r[rdf_pkg::VALUE_BITS-2:0], fits};
      if (div_last) begin
        // remainder goes to the store, quotient stays for the next digit
        part_nxt = '0;
        step_nxt = '0;
        cnt_nxt  = cnt_r + CW'(1);
      end else begin
        part_nxt = part_step;
        step_nxt = step_r + rdf_pkg::STEP_W'(1);
      end
    end
    if (cmd.emit) begin
      valid_nxt           = 1'b1;
      out_nxt.character   = rdf_pkg::digit_to_ascii(rd_digit);
      out_nxt.last        = 1'b0;
      out_nxt.bad_radix   = 1'b0;
      cnt_nxt             = cnt_dec;
    end
    if (cmd.newline) begin
      valid_nxt           = 1'b1;
      out_nxt.character   = rdf_pkg::ASCII_NL;
      out_nxt.last        = 1'b1;
      out_nxt.bad_radix   = bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      step_r  <= '0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      rem_r   <= rem_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r  <= part_nxt;
    radix_r <= radix_nxt;
    bad_r   <= bad_nxt;
    out_r   <= out_nxt;
  end

  assign stat.rem_zero = rem_r == '0;
  assign stat.cnt_full = cnt_r == CW'(DIGIT_DEPTH);
  assign stat.cnt_zero = cnt_r == '0;
  assign stat.cnt_one  = cnt_r == CW'(1);
  assign stat.div_last = div_last;

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[sv/rdf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_ctrl
// Sequencer for divide, store readback and character emission.
// ----------------------------------------------------------------------------
module rdf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rdf_pkg::dp_stat_t stat,
  output rdf_pkg::dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_READ  = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_NL    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.rem_zero && !stat.cnt_full) begin
          state_nxt = ST_DIV;
        end else if (stat.cnt_zero) begin
          state_nxt = ST_NL;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;   // store read latency
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = stat.cnt_one ? ST_NL : ST_READ;
      end
      ST_NL: begin
        cmd.newline = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule
`default_nettype wire

[sv/radix_digit_formatter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_formatter_unit
// Formats a signed 32-bit value as ASCII digits in a radix from 2 to 63.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The unit emits
// the digits most significant first ('0'-'9', 'A'-'Z', '?' for digit values
// of 36 and up), then one newline (0x0A) with last set. Zero or negative
// values give only the newline; a radix below 2 gives only the newline with
// bad_radix set. Each character sits on out_data for exactly one cycle with
// out_valid high; the receiver cannot stall, so it must take every strobe.
// Sequence: busy stays high while a transaction of n <= 31 digits runs. Each
// digit takes the steps of the bit-serial restoring divider plus one check
// step, with one more check at the start; readback of each digit takes a
// read state and an emit state because the digit store has a registered read
// port; the newline follows. The newline appears in the first cycle with busy
// low, and the next start may be accepted in that same cycle.
// ----------------------------------------------------------------------------
module radix_digit_formatter_unit #(
  parameter int DIGIT_DEPTH = 32    // digit store entries, 31 to 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire rdf_pkg::in_t in_data,
  output logic              out_valid,
  output rdf_pkg::out_t     out_data
);

  rdf_pkg::dp_cmd_t  cmd;
  rdf_pkg::dp_stat_t stat;

  // Sequencer: owns the handshake and steps the datapath
  rdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Divider, digit store and registered result
  rdf_datapath #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
